/* rtl/obb_overlap_separating_axis_defines.svh */
// Assertion macros shared by the oriented-box overlap test RTL.
// No dependencies; included by obb_sat_ctrl, the file that carries assertions.
`ifndef OBB_OVERLAP_SEPARATING_AXIS_DEFINES_SVH
`define OBB_OVERLAP_SEPARATING_AXIS_DEFINES_SVH

// Implication checked at every edge out of reset.
`define OBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obb check failed");

// Consequent checked in the cycle after the antecedent.
`define OBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obb check failed");

`endif

/* rtl/obb_sat_pkg.sv */
// Shared types, constants and helpers for the oriented-box overlap test.
// No dependencies.
package obb_sat_pkg;

  localparam int DirW     = 16;
  localparam int HalfW    = 31;
  localparam int CoordW   = 32;
  localparam int DirFrac  = 14;  // fraction bits of a direction
  localparam int AxisCnt  = 3;
  localparam int SlotCnt  = 6;
  localparam int SlotW    = 3;
  localparam int NW       = 19;  // cross-product axis component
  localparam int LW       = 56;  // projected center distance accumulator
  localparam int TW       = 38;  // edge projection accumulator
  localparam int RW       = 58;  // radius sum

  typedef enum logic [2:0] {
    OP_NONE,
    OP_NCOPY,
    OP_NCROSS,
    OP_LDOT,
    OP_RINIT,
    OP_TDOT,
    OP_TMUL
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [1:0]       comp;
    logic [SlotW-1:0] sel_a;
    logic [SlotW-1:0] sel_b;
    logic             face;
  } dp_cmd_t;

  typedef struct packed {
    logic sep;
  } dp_stat_t;

  // next component index, modulo three
  function automatic logic [1:0] inc3(input logic [1:0] x);
    logic [1:0] r;
    case (x)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/obb_overlap_separating_axis.sv */
// Top level of the oriented-box overlap test (15-axis separating axis test).
// Depends on obb_sat_pkg, obb_sat_ctrl and obb_sat_dp.
//
//   channel | signals                          | word
//   in      | in_valid_i / in_ready_o          | one box axis, center, last flag
//   out     | out_valid_o / out_ready_i        | hit flag, one per last-marked word
//
// A load word without last is taken whenever the sequencer is idle. A last-marked
// word starts the test: face axes, then edge axes, are evaluated one after another
// on one shared datapath, and the result is registered; a separating axis ends early.
// Input is held off while the test runs. A pending result does not block loading;
// a new result waits in the sequencer until the previous one is taken.
// Reset clears the sequencer and result valid; box storage is not cleared.
module obb_overlap_separating_axis (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  box_select_i,
  input  logic [1:0]                            axis_index_i,
  input  logic signed [obb_sat_pkg::DirW-1:0]   dir_x_i,
  input  logic signed [obb_sat_pkg::DirW-1:0]   dir_y_i,
  input  logic signed [obb_sat_pkg::DirW-1:0]   dir_z_i,
  input  logic [obb_sat_pkg::HalfW-1:0]         half_length_i,
  input  logic signed [obb_sat_pkg::CoordW-1:0] center_x_i,
  input  logic signed [obb_sat_pkg::CoordW-1:0] center_y_i,
  input  logic signed [obb_sat_pkg::CoordW-1:0] center_z_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  hit_o
);
  import obb_sat_pkg::*;

  logic     wr_en, start;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign wr_en = in_valid_i && in_ready_o;
  assign start = wr_en && last_i;

  obb_sat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  obb_sat_dp u_dp (
    .clk_i         (clk_i),
    .wr_en_i       (wr_en),
    .box_select_i  (box_select_i),
    .axis_index_i  (axis_index_i),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .half_length_i (half_length_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .center_z_i    (center_z_i),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

/* rtl/obb_sat_dp.sv */
// Datapath: box storage, axis vector, projection accumulators, compare.
// Depends on obb_sat_pkg.
module obb_sat_dp (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic                                box_select_i,
  input  logic [1:0]                          axis_index_i,
  input  logic signed [obb_sat_pkg::DirW-1:0] dir_x_i,
  input  logic signed [obb_sat_pkg::DirW-1:0] dir_y_i,
  input  logic signed [obb_sat_pkg::DirW-1:0] dir_z_i,
  input  logic [obb_sat_pkg::HalfW-1:0]       half_length_i,
  input  logic signed [obb_sat_pkg::CoordW-1:0] center_x_i,
  input  logic signed [obb_sat_pkg::CoordW-1:0] center_y_i,
  input  logic signed [obb_sat_pkg::CoordW-1:0] center_z_i,
  input  obb_sat_pkg::dp_cmd_t                cmd_i,
  output obb_sat_pkg::dp_stat_t               stat_o
);
  import obb_sat_pkg::*;

  logic signed [DirW-1:0]   dir_q  [SlotCnt][AxisCnt];
  logic [HalfW-1:0]         half_q [SlotCnt];
  logic signed [CoordW-1:0] ctr_q  [SlotCnt];
  logic signed [NW-1:0]     n_q    [AxisCnt];
  logic signed [LW-1:0]     l_q;
  logic signed [TW-1:0]     t_q;
  logic [RW-1:0]            r_q;

  logic [SlotW-1:0]         wr_slot, ctr_base;
  logic [1:0]               c0, c1, c2;
  logic signed [2*DirW-1:0] pa, pb;
  logic signed [2*DirW:0]   cr;
  logic [2*DirW:0]          cr_mag, cr_sh;
  logic signed [NW-1:0]     n_new;
  logic signed [CoordW:0]   iv;
  logic signed [CoordW+NW-1:0] lprod;
  logic signed [NW+DirW-1:0]   tprod;
  logic [TW-1:0]            t_mag, t_sh;
  logic [22+HalfW-1:0]      rprod;
  logic [LW-1:0]            l_mag;

  assign wr_slot  = box_select_i ? (SlotW'(AxisCnt) + {1'b0, axis_index_i})
                                 : {1'b0, axis_index_i};
  assign ctr_base = box_select_i ? SlotW'(AxisCnt) : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (axis_index_i < 2'(AxisCnt)) begin
        dir_q[wr_slot][0] <= dir_x_i;
        dir_q[wr_slot][1] <= dir_y_i;
        dir_q[wr_slot][2] <= dir_z_i;
        half_q[wr_slot]   <= half_length_i;
      end
      ctr_q[ctr_base]        <= center_x_i;
      ctr_q[ctr_base + 3'd1] <= center_y_i;
      ctr_q[ctr_base + 3'd2] <= center_z_i;
    end
  end

  assign c0 = cmd_i.comp;
  assign c1 = inc3(c0);
  assign c2 = inc3(c1);

  // cross-product component, truncated toward zero to direction scale
  always_comb begin
    pa     = dir_q[cmd_i.sel_a][c1] * dir_q[cmd_i.sel_b][c2];
    pb     = dir_q[cmd_i.sel_a][c2] * dir_q[cmd_i.sel_b][c1];
    cr     = {pa[2*DirW-1], pa} - {pb[2*DirW-1], pb};
    cr_mag = cr[2*DirW] ? (2*DirW+1)'(-cr) : cr;
    cr_sh  = cr_mag >> DirFrac;
    n_new  = cr[2*DirW] ? -$signed(cr_sh[NW-1:0]) : $signed(cr_sh[NW-1:0]);
  end

  always_comb begin
    iv    = {ctr_q[{1'b0, c0}][CoordW-1], ctr_q[{1'b0, c0}]}
          - {ctr_q[SlotW'(AxisCnt) + {1'b0, c0}][CoordW-1],
             ctr_q[SlotW'(AxisCnt) + {1'b0, c0}]};
    lprod = iv * n_q[c0];
    tprod = n_q[c0] * dir_q[cmd_i.sel_a][c0];
    t_mag = t_q[TW-1] ? TW'(-t_q) : t_q;
    t_sh  = t_mag >> DirFrac;
    rprod = t_sh[21:0] * half_q[cmd_i.sel_a];
    l_mag = l_q[LW-1] ? LW'(-l_q) : l_q;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_NCOPY:  n_q[c0] <= NW'(dir_q[cmd_i.sel_a][c0]);
      OP_NCROSS: n_q[c0] <= n_new;
      OP_LDOT:   l_q <= ((c0 == 2'd0) ? '0 : l_q) + LW'(lprod);
      OP_TDOT:   t_q <= ((c0 == 2'd0) ? '0 : t_q) + TW'(tprod);
      OP_RINIT:  r_q <= cmd_i.face ? RW'({half_q[cmd_i.sel_a], {DirFrac{1'b0}}}) : '0;
      OP_TMUL:   r_q <= r_q + RW'(rprod);
      default: ;
    endcase
  end

  assign stat_o.sep = RW'(l_mag) > r_q;

endmodule

/* rtl/obb_sat_ctrl.sv */
// Sequencer for the fifteen-axis test and the result register.
// Depends on obb_sat_pkg and obb_overlap_separating_axis_defines.svh.
`include "obb_overlap_separating_axis_defines.svh"

module obb_sat_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output obb_sat_pkg::dp_cmd_t  cmd_o,
  input  obb_sat_pkg::dp_stat_t stat_i
);
  import obb_sat_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NVEC, ST_LDOT, ST_RINIT, ST_TDOT, ST_TMUL, ST_CMP, ST_DONE
  } state_e;

  typedef enum logic [1:0] {CL_FACE_A, CL_FACE_B, CL_EDGE} cls_e;

  state_e     state_q;
  cls_e       cls_q;
  logic [1:0] i_q, j_q, c_q, t_q;
  logic       res_q, out_valid_q, hit_q;

  logic [SlotW-1:0] own_slot, term_slot;
  logic             last_term, last_axis;

  always_comb begin
    own_slot  = (cls_q == CL_FACE_B) ? (SlotW'(AxisCnt) + {1'b0, i_q}) : {1'b0, i_q};
    term_slot = '0;
    case (cls_q)
      CL_FACE_A: term_slot = SlotW'(AxisCnt) + {1'b0, t_q};
      CL_FACE_B: term_slot = {1'b0, t_q};
      default: begin
        case (t_q)
          2'd0:    term_slot = {1'b0, inc3(i_q)};
          2'd1:    term_slot = {1'b0, inc3(inc3(i_q))};
          2'd2:    term_slot = SlotW'(AxisCnt) + {1'b0, inc3(j_q)};
          default: term_slot = SlotW'(AxisCnt) + {1'b0, inc3(inc3(j_q))};
        endcase
      end
    endcase
    last_term = (cls_q == CL_EDGE) ? (t_q == 2'd3) : (t_q == 2'd2);
    last_axis = (cls_q == CL_EDGE) && (i_q == 2'd2) && (j_q == 2'd2);
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;
    cmd_o.comp  = c_q;
    cmd_o.sel_b = SlotW'(AxisCnt) + {1'b0, j_q};
    cmd_o.face  = (cls_q != CL_EDGE);
    case (state_q)
      ST_NVEC: begin
        cmd_o.op    = (cls_q == CL_EDGE) ? OP_NCROSS : OP_NCOPY;
        cmd_o.sel_a = own_slot;
      end
      ST_LDOT:  cmd_o.op = OP_LDOT;
      ST_RINIT: begin
        cmd_o.op    = OP_RINIT;
        cmd_o.sel_a = own_slot;
      end
      ST_TDOT: begin
        cmd_o.op    = OP_TDOT;
        cmd_o.sel_a = term_slot;
      end
      ST_TMUL: begin
        cmd_o.op    = OP_TMUL;
        cmd_o.sel_a = term_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cls_q       <= CL_FACE_A;
      i_q         <= '0;
      j_q         <= '0;
      c_q         <= '0;
      t_q         <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      // in ST_DONE the valid flag is handled by the state itself
      if (out_valid_q && out_ready_i && state_q != ST_DONE) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            cls_q   <= CL_FACE_A;
            i_q     <= '0;
            j_q     <= '0;
            c_q     <= '0;
            state_q <= ST_NVEC;
          end
        end
        ST_NVEC: begin
          c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
          if (c_q == 2'd2) state_q <= ST_LDOT;
        end
        ST_LDOT: begin
          c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
          if (c_q == 2'd2) state_q <= ST_RINIT;
        end
        ST_RINIT: begin
          t_q     <= '0;
          state_q <= ST_TDOT;
        end
        ST_TDOT: begin
          c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
          if (c_q == 2'd2) state_q <= ST_TMUL;
        end
        ST_TMUL: begin
          t_q     <= t_q + 2'd1;
          state_q <= last_term ? ST_CMP : ST_TDOT;
        end
        ST_CMP: begin
          if (stat_i.sep) begin
            res_q   <= 1'b0;
            state_q <= ST_DONE;
          end else if (last_axis) begin
            res_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_NVEC;
            case (cls_q)
              CL_FACE_A: begin
                if (i_q == 2'd2) begin
                  cls_q <= CL_FACE_B;
                  i_q   <= '0;
                end else i_q <= i_q + 2'd1;
              end
              CL_FACE_B: begin
                if (i_q == 2'd2) begin
                  cls_q <= CL_EDGE;
                  i_q   <= '0;
                  j_q   <= '0;
                end else i_q <= i_q + 2'd1;
              end
              default: begin
                if (j_q == 2'd2) begin
                  j_q <= '0;
                  i_q <= i_q + 2'd1;
                end else j_q <= j_q + 2'd1;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            hit_q       <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  `OBB_ASSERT_NXT(a_start_leaves_idle, clk_i, rst_ni, state_q == ST_IDLE && start_i, state_q == ST_NVEC)
  `OBB_ASSERT_NXT(a_done_holds, clk_i, rst_ni, state_q == ST_DONE && out_valid_q && !out_ready_i, state_q == ST_DONE && out_valid_q)
  `OBB_ASSERT_IMP(a_word_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DONE))

endmodule
